### hdl/lfid_pkg.sv
// shared types, constants and helpers for the lowest free identifier allocator
`timescale 1ns / 1ps
package lfid_pkg;

    localparam int NUM_IDS_DEF = 4096;
    localparam int ID_W        = 16;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int BYTE_CNT    = WORD_W / 8;

    localparam logic [ID_W-1:0] ID_BASE_RESET = 16'd300;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic rd_next;
        logic eval;
        logic res_range;
        logic res_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_release;
        logic in_range;
        logic word_free;
        logic last_word;
        logic clr_last;
    } t_stat;

    // lowest clear bit of a word: byte first, then bit within the byte
    function automatic logic [BIT_W-1:0] lfid_ffz(input logic [WORD_W-1:0] word);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] byte_val;
        byte_sel = '0;
        bit_sel  = '0;
        for (int b = BYTE_CNT - 1; b >= 0; b--) begin
            if (~&word[b*8 +: 8]) begin
                byte_sel = 3'(b);
            end
        end
        byte_val = word[byte_sel*8 +: 8];
        for (int k = 7; k >= 0; k--) begin
            if (!byte_val[k]) begin
                bit_sel = 3'(k);
            end
        end
        return {byte_sel, bit_sel};
    endfunction

endpackage

### hdl/lfid_datapath.sv
// bitmap memory, word scan datapath, base register and result registers
`timescale 1ns / 1ps
module lfid_datapath
    import lfid_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_cfg_wdata,
    input  logic            i_opcode,
    input  logic [ID_W-1:0] i_release_id,
    input  t_cmd            i_cmd,
    output t_stat           o_stat,
    output logic [ID_W-1:0] o_granted_id,
    output logic [1:0]      o_status
);

    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = WADDR_W + BIT_W;
    localparam int CMP_W     = 18;

    logic [WORD_W-1:0]  r_mem [NUM_WORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic [ID_W-1:0]    r_id_base;
    logic               r_op;
    logic               r_in_range;
    logic [WADDR_W-1:0] r_addr;
    logic [BIT_W-1:0]   r_bit;
    logic [WADDR_W-1:0] r_clr_addr;
    logic [ID_W-1:0]    r_granted;
    logic [1:0]         r_status;
    logic [ID_W-1:0]    r_out_granted;
    logic [1:0]         r_out_status;

    logic [CMP_W-1:0]   off;
    logic               off_ok;
    logic [WADDR_W-1:0] rd_addr;
    logic [BIT_W-1:0]   ffz;
    logic               word_free;
    logic [IDX_W-1:0]   idx;
    logic [CMP_W-1:0]   id_sum;
    logic               fits;
    logic [BIT_W-1:0]   bit_sel;
    logic [WORD_W-1:0]  mask;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    assign off    = CMP_W'(i_release_id) - CMP_W'(r_id_base);
    assign off_ok = (i_release_id >= r_id_base) && (off < CMP_W'(NUM_IDS));

    assign rd_addr   = i_cmd.rd_next ? r_addr + 1'b1 : r_addr;
    assign ffz       = lfid_ffz(r_rdata);
    assign word_free = ~&r_rdata;
    assign idx       = {r_addr, ffz};
    assign id_sum    = CMP_W'(r_id_base) + CMP_W'(idx);
    assign fits      = (CMP_W'(idx) < CMP_W'(NUM_IDS)) && (id_sum <= CMP_W'(16'hFFFF));

    assign bit_sel = r_op ? r_bit : ffz;
    assign mask    = WORD_W'(1) << bit_sel;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata | mask;
        if (i_cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.eval) begin
            mem_we    = r_op || fits;
            mem_wdata = r_op ? (r_rdata & ~mask) : (r_rdata | mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd || i_cmd.rd_next) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base  <= ID_BASE_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_id_base <= i_cfg_wdata;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_in_range <= off_ok;
            r_bit      <= off[BIT_W-1:0];
            r_addr     <= (i_opcode == OP_RELEASE) ? off[BIT_W +: WADDR_W] : '0;
        end else if (i_cmd.rd_next) begin
            r_addr <= rd_addr;
        end

        if (i_cmd.res_range) begin
            r_granted <= '0;
            r_status  <= ST_RANGE;
        end else if (i_cmd.res_full) begin
            r_granted <= '0;
            r_status  <= ST_FULL;
        end else if (i_cmd.eval) begin
            if (r_op == OP_RELEASE) begin
                r_granted <= '0;
                r_status  <= ST_OK;
            end else if (fits) begin
                r_granted <= id_sum[ID_W-1:0];
                r_status  <= ST_OK;
            end else begin
                r_granted <= '0;
                r_status  <= ST_FULL;
            end
        end

        if (i_cmd.out_load) begin
            r_out_granted <= r_granted;
            r_out_status  <= r_status;
        end
    end

    assign o_stat.is_release = (r_op == OP_RELEASE);
    assign o_stat.in_range   = r_in_range;
    assign o_stat.word_free  = word_free;
    assign o_stat.last_word  = (r_addr == WADDR_W'(NUM_WORDS - 1));
    assign o_stat.clr_last   = (r_clr_addr == WADDR_W'(NUM_WORDS - 1));

    assign o_granted_id = r_out_granted;
    assign o_status     = r_out_status;

endmodule

### hdl/lfid_ctrl.sv
// control state machine: clearing pass, request sequencing and response handshake
`timescale 1ns / 1ps
module lfid_ctrl
    import lfid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    output logic  o_rsp_valid,
    input  logic  i_rsp_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_rsp_valid;
    logic       n_rsp_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.is_release && !i_stat.in_range) begin
                    o_cmd.res_range = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_stat.is_release || i_stat.word_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = S_DONE;
                end else if (i_stat.last_word) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

### hdl/lowest_free_id_allocator.sv
// IDLE accepts; START reads a bitmap word or ends an out of range release; EVAL
// clears the released bit or sets the lowest free one, scanning 64-bit words from
// 0 (full after the last); DONE registers the response. One transaction at a time;
// a new request is taken once the response is registered, also while it waits.
// reset: synchronous, active low; a clearing pass zeroes the ceil(NUM_IDS/64)
// bitmap words (64 by default); requests wait, configuration writes go through
`timescale 1ns / 1ps
module lowest_free_id_allocator
    import lfid_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [ID_W-1:0] i_cfg_wdata,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  logic            i_opcode,
    input  logic [ID_W-1:0] i_release_id,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output logic [ID_W-1:0] o_granted_id,
    output logic [1:0]      o_status
);

    t_cmd  cmd;
    t_stat stat;

    lfid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lfid_datapath #(
        .NUM_IDS (NUM_IDS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_release_id (i_release_id),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

endmodule

### hdl/lfid_checker.sv
// port level checks for the allocator, bound to the top level
`timescale 1ns / 1ps
module lfid_checker
    import lfid_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_ready,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input logic [ID_W-1:0] o_granted_id,
    input logic [1:0]      o_status
);

    // no request taken in the first cycle out of reset: clearing pass runs
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_req_ready)
        else $error("request ready during bitmap clearing pass");

    // one transaction in flight
    a_single_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("second request taken while one is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_RANGE))
        else $error("unused status code on response");

    a_granted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status != ST_OK) |-> (o_granted_id == '0))
        else $error("nonzero identifier on failed transaction");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=>
            (o_rsp_valid && $stable(o_granted_id) && $stable(o_status)))
        else $error("stalled response changed");

endmodule

bind lowest_free_id_allocator lfid_checker u_lfid_checker (.*);
